FILE: rtl/smn_pkg.sv
// ----------------------------------------------------------------------------
// smn_pkg: shared types and helpers for the short name mangler
// Word formats, the name record handed from front to back, the 42-entry
// hash character table and the byte helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package smn_pkg;

    localparam int BASE_CHARS = 5;
    localparam int EXT_CHARS  = 3;

    localparam int BASE_CNT_W = $clog2(BASE_CHARS + 1);
    localparam int EXT_CNT_W  = $clog2(EXT_CHARS + 1);
    localparam int BASE_IDX_W = (BASE_CHARS > 1) ? $clog2(BASE_CHARS) : 1;
    localparam int EXT_IDX_W  = (EXT_CHARS > 1) ? $clog2(EXT_CHARS) : 1;

    // base, '~', two hash chars, '.', extension
    localparam int MAX_LINE = BASE_CHARS + 4 + EXT_CHARS;
    localparam int LINE_W   = $clog2(MAX_LINE + 1);
    localparam int LEN_W    = 5;

    localparam int TABLE_SIZE = 42;
    localparam int DIGIT_W    = 6;
    // floor(b * 781 / 2^15) == floor(b / 42) for every 8-bit b
    localparam int RECIP_42   = 781;
    localparam int RECIP_SH   = 15;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] DOT_CHAR   = 8'h2E;
    localparam logic [7:0] TILDE_CHAR = 8'h7E;
    localparam logic [7:0] NUL_CHAR   = 8'h00;

    localparam logic [0:TABLE_SIZE-1][7:0] MANGLE_TABLE =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ_-!@#$";

    typedef struct packed {
        logic [7:0] name_byte;
        logic       final_byte;
    } smn_in_t;

    typedef struct packed {
        logic [7:0]       short_char;
        logic             run_end;
        logic             no_short_name;
        logic [LEN_W-1:0] utf16_length;
    } smn_out_t;

    // one finished long name, ready to be spelled out
    typedef struct packed {
        logic                            leading_dot;
        logic [BASE_CNT_W-1:0]           base_count;
        logic [BASE_CHARS-1:0][7:0]      base_chars;
        logic [EXT_CNT_W-1:0]            ext_count;
        logic [EXT_CHARS-1:0][7:0]       ext_chars;
        logic [DIGIT_W-1:0]              hash_hi;
        logic [DIGIT_W-1:0]              hash_lo;
    } smn_name_t;

    typedef struct packed {
        logic full;
        logic empty;
    } smn_q_status_t;

    typedef struct packed {
        logic [2:0]         quo;
        logic [DIGIT_W-1:0] rem;
    } smn_div_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end else if (c >= 8'hE0 && c <= 8'hFE && c != 8'hF7) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    function automatic smn_div_t split42(input logic [7:0] b);
        logic [17:0] prod;
        logic [7:0]  back;
        smn_div_t    d;
        prod  = {10'd0, b} * 18'(RECIP_42);
        d.quo = prod[RECIP_SH+2:RECIP_SH];
        back  = {5'd0, d.quo} * 8'(TABLE_SIZE);
        d.rem = DIGIT_W'(b - back);
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/smn_front.sv
// ----------------------------------------------------------------------------
// smn_front: name byte intake
// Captures base and extension characters, keeps the hash as two base-42
// digits, and pushes a finished name record on the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module smn_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire smn_pkg::smn_in_t     s_word,
    input  wire smn_pkg::smn_q_status_t q_status,
    output logic                      q_push,
    output smn_pkg::smn_name_t        q_name
);

    logic [smn_pkg::BASE_CHARS-1:0][7:0] base_store_reg, base_store_next;
    logic [smn_pkg::EXT_CHARS-1:0][7:0]  ext_store_reg, ext_store_next;
    logic [smn_pkg::BASE_CNT_W-1:0] base_count_reg, base_count_next, base_count_new;
    logic [smn_pkg::EXT_CNT_W-1:0]  ext_count_reg, ext_count_next, ext_count_new;
    logic dot_seen_reg, dot_seen_next, dot_seen_new;
    logic at_start_reg, at_start_next;
    logic lead_dot_reg, lead_dot_next, lead_dot_new;
    logic [smn_pkg::DIGIT_W-1:0] hi_reg, hi_next, hi_new;
    logic [smn_pkg::DIGIT_W-1:0] lo_reg, lo_next, lo_new;

    logic               accept;
    logic               is_dot;
    logic [7:0]         up;
    logic               base_fill, ext_fill;
    smn_pkg::smn_div_t  split;
    logic [smn_pkg::DIGIT_W:0] lo_sum, hi_sum;
    logic               carry;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        is_dot    = (s_word.name_byte == smn_pkg::DOT_CHAR);
        up        = smn_pkg::upcase(s_word.name_byte);
        base_fill = base_count_reg < smn_pkg::BASE_CNT_W'(smn_pkg::BASE_CHARS);
        ext_fill  = dot_seen_reg &&
                    (ext_count_reg < smn_pkg::EXT_CNT_W'(smn_pkg::EXT_CHARS));

        base_store_next = base_store_reg;
        base_count_new  = base_count_reg;
        ext_store_next  = ext_store_reg;
        ext_count_new   = ext_count_reg;
        if (is_dot) begin
            ext_count_new = '0;
        end else begin
            if (base_fill) begin
                base_store_next[base_count_reg[smn_pkg::BASE_IDX_W-1:0]] = up;
                base_count_new = base_count_reg + 1'b1;
            end
            if (ext_fill) begin
                ext_store_next[ext_count_reg[smn_pkg::EXT_IDX_W-1:0]] = up;
                ext_count_new = ext_count_reg + 1'b1;
            end
        end
        dot_seen_new = dot_seen_reg || is_dot;
        lead_dot_new = at_start_reg ? is_dot : lead_dot_reg;

        // sum mod 1764 kept as hi*42 + lo
        split  = smn_pkg::split42(s_word.name_byte);
        lo_sum = {1'b0, lo_reg} + {1'b0, split.rem};
        carry  = lo_sum >= (smn_pkg::DIGIT_W+1)'(smn_pkg::TABLE_SIZE);
        lo_new = carry ? smn_pkg::DIGIT_W'(lo_sum - (smn_pkg::DIGIT_W+1)'(smn_pkg::TABLE_SIZE))
                       : lo_sum[smn_pkg::DIGIT_W-1:0];
        hi_sum = {1'b0, hi_reg} + (smn_pkg::DIGIT_W+1)'(split.quo)
               + (smn_pkg::DIGIT_W+1)'(carry);
        hi_new = (hi_sum >= (smn_pkg::DIGIT_W+1)'(smn_pkg::TABLE_SIZE))
               ? smn_pkg::DIGIT_W'(hi_sum - (smn_pkg::DIGIT_W+1)'(smn_pkg::TABLE_SIZE))
               : hi_sum[smn_pkg::DIGIT_W-1:0];

        q_push             = accept && s_word.final_byte;
        q_name.leading_dot = lead_dot_new;
        q_name.base_count  = base_count_new;
        q_name.base_chars  = base_store_next;
        q_name.ext_count   = ext_count_new;
        q_name.ext_chars   = ext_store_next;
        q_name.hash_hi     = hi_new;
        q_name.hash_lo     = lo_new;

        base_count_next = base_count_reg;
        ext_count_next  = ext_count_reg;
        dot_seen_next   = dot_seen_reg;
        at_start_next   = at_start_reg;
        lead_dot_next   = lead_dot_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        if (accept) begin
            if (s_word.final_byte) begin
                base_count_next = '0;
                ext_count_next  = '0;
                dot_seen_next   = 1'b0;
                at_start_next   = 1'b1;
                lead_dot_next   = 1'b0;
                hi_next         = '0;
                lo_next         = '0;
            end else begin
                base_count_next = base_count_new;
                ext_count_next  = ext_count_new;
                dot_seen_next   = dot_seen_new;
                at_start_next   = 1'b0;
                lead_dot_next   = lead_dot_new;
                hi_next         = hi_new;
                lo_next         = lo_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_count_reg <= '0;
            ext_count_reg  <= '0;
            dot_seen_reg   <= 1'b0;
            at_start_reg   <= 1'b1;
            lead_dot_reg   <= 1'b0;
            hi_reg         <= '0;
            lo_reg         <= '0;
        end else begin
            base_count_reg <= base_count_next;
            ext_count_reg  <= ext_count_next;
            dot_seen_reg   <= dot_seen_next;
            at_start_reg   <= at_start_next;
            lead_dot_reg   <= lead_dot_next;
            hi_reg         <= hi_next;
            lo_reg         <= lo_next;
        end
    end

    // character stores: contents only matter below their counts
    always_ff @(posedge aclk) begin
        if (accept) begin
            base_store_reg <= base_store_next;
            ext_store_reg  <= ext_store_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/smn_queue.sv
// ----------------------------------------------------------------------------
// smn_queue: name record queue
// Small FIFO of finished names between intake and output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module smn_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire smn_pkg::smn_name_t   push_name,
    input  wire logic                 pop,
    output smn_pkg::smn_name_t        head_name,
    output smn_pkg::smn_q_status_t    status
);

    smn_pkg::smn_name_t            slot_reg [smn_pkg::QDEPTH];
    logic [smn_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [smn_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [smn_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          do_push, do_pop;

    function automatic logic [smn_pkg::QPTR_W-1:0] bump(
        input logic [smn_pkg::QPTR_W-1:0] p);
        logic [smn_pkg::QPTR_W-1:0] r;
        r = (p == smn_pkg::QPTR_W'(smn_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    always_comb begin
        status.full  = (count_reg == smn_pkg::QCNT_W'(smn_pkg::QDEPTH));
        status.empty = (count_reg == '0);
        do_push      = push && !status.full;
        do_pop       = pop && !status.empty;
        head_name    = slot_reg[rd_ptr_reg];
        wr_ptr_next  = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next  = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next   = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_name;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/smn_back.sv
// ----------------------------------------------------------------------------
// smn_back: short name sequencer
// Spells out BASE~HL.EXT from the head name record, one word per cycle
// while m_ready allows, into the output register (one word if dot-led).
// ----------------------------------------------------------------------------
`default_nettype none

module smn_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire smn_pkg::smn_name_t    head_name,
    input  wire smn_pkg::smn_q_status_t q_status,
    output logic                       q_pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output smn_pkg::smn_out_t          m_word
);

    localparam logic [smn_pkg::LINE_W-1:0] TILDE_POS = smn_pkg::LINE_W'(0);
    localparam logic [smn_pkg::LINE_W-1:0] HI_POS    = smn_pkg::LINE_W'(1);
    localparam logic [smn_pkg::LINE_W-1:0] LO_POS    = smn_pkg::LINE_W'(2);
    localparam logic [smn_pkg::LINE_W-1:0] DOT_POS   = smn_pkg::LINE_W'(3);
    localparam logic [smn_pkg::LINE_W-1:0] EXT_POS   = smn_pkg::LINE_W'(4);

    logic [smn_pkg::LINE_W-1:0] pos_reg, pos_next;
    logic                       m_valid_reg, m_valid_next;
    smn_pkg::smn_out_t          m_word_reg;

    logic [smn_pkg::LINE_W-1:0] base_len, line_len, rel, ext_rel;
    logic                       last;
    logic                       load;
    smn_pkg::smn_out_t          word;

    always_comb begin
        base_len = smn_pkg::LINE_W'(head_name.base_count);
        line_len = base_len + EXT_POS + smn_pkg::LINE_W'(head_name.ext_count);
        rel      = pos_reg - base_len;
        ext_rel  = rel - EXT_POS;

        if (pos_reg < base_len) begin
            word.short_char = head_name.base_chars[pos_reg[smn_pkg::BASE_IDX_W-1:0]];
        end else begin
            case (rel)
                TILDE_POS: word.short_char = smn_pkg::TILDE_CHAR;
                HI_POS:    word.short_char = smn_pkg::MANGLE_TABLE[head_name.hash_hi];
                LO_POS:    word.short_char = smn_pkg::MANGLE_TABLE[head_name.hash_lo];
                DOT_POS:   word.short_char = smn_pkg::DOT_CHAR;
                default:   word.short_char =
                               head_name.ext_chars[ext_rel[smn_pkg::EXT_IDX_W-1:0]];
            endcase
        end

        if (head_name.leading_dot) begin
            last               = 1'b1;
            word.short_char    = smn_pkg::NUL_CHAR;
            word.no_short_name = 1'b1;
            word.utf16_length  = '0;
        end else begin
            last               = (pos_reg == line_len - 1'b1);
            word.no_short_name = 1'b0;
            word.utf16_length  = smn_pkg::LEN_W'({line_len, 1'b0});
        end
        word.run_end = last;

        load  = !q_status.empty && (!m_valid_reg || m_ready);
        q_pop = load && last;

        pos_next = pos_reg;
        if (load) begin
            pos_next = last ? '0 : pos_reg + 1'b1;
        end
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_word_reg <= word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

`default_nettype wire

FILE: rtl/short_name_mangler.sv
// ----------------------------------------------------------------------------
// short_name_mangler: 8.3 style short name generator
// Turns a long file name, streamed one byte per word, into BASE~HL.EXT.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one long-name byte per word, final_byte set on the last.
//     The intake takes a word every cycle while the name queue has room;
//     s_ready drops only when two finished names are still waiting.
//   m_* channel: one short-name character per word, run_end on the last.
//     A name that starts with '.' gives one word with no_short_name set
//     and a zero character. utf16_length repeats twice the char count.
//   Flow: the final byte is queued at the edge that takes it; with the
//     output idle the first character is loaded into the output register
//     at the next edge. A name then drains at one word per cycle while
//     m_ready is high, 5 to 12 words (one for a dot-led name).
//   Throughput: one input byte per cycle; output is bounded by one word
//     per cycle from the output register, so names shorter than their
//     short form back up into the two-entry queue and then stall s_ready.
//   Reset (aresetn low, synchronous): partial name dropped, queue emptied,
//     m_valid low. A stalled m_ready holds the output word; intake keeps
//     running until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module short_name_mangler (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire smn_pkg::smn_in_t  s_word,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output smn_pkg::smn_out_t      m_word
);

    smn_pkg::smn_q_status_t q_status;
    smn_pkg::smn_name_t     push_name;
    smn_pkg::smn_name_t     head_name;
    logic                   q_push;
    logic                   q_pop;

    // front: capture chars, track hash digits, emit a record per name
    smn_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_word   (s_word),
        .q_status (q_status),
        .q_push   (q_push),
        .q_name   (push_name)
    );

    // decouples intake from the output burst
    smn_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_name (push_name),
        .pop       (q_pop),
        .head_name (head_name),
        .status    (q_status)
    );

    // back: walks the head record one character per word
    smn_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_name (head_name),
        .q_status  (q_status),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

endmodule

`default_nettype wire

FILE: rtl/smn_checker.sv
// ----------------------------------------------------------------------------
// smn_checker: port-level checks for the short name mangler
// Output word shape, output register and input flag; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module smn_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire smn_pkg::smn_in_t  s_word,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire smn_pkg::smn_out_t m_word
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("output word changed while stalled");

    a_empty_name: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.no_short_name |->
            m_word.run_end && m_word.short_char == smn_pkg::NUL_CHAR &&
            m_word.utf16_length == '0)
        else $error("bad empty-name word");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word.no_short_name |->
            m_word.utf16_length >= smn_pkg::LEN_W'(8) &&
            m_word.utf16_length <= smn_pkg::LEN_W'(2 * smn_pkg::MAX_LINE))
        else $error("utf16_length out of range");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

    a_in_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !$isunknown(s_word.final_byte))
        else $error("final flag unknown on accepted word");

endmodule

bind short_name_mangler smn_checker u_smn_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_word  (s_word),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);

`default_nettype wire
